@@ hdl/scs_pkg.sv @@
// Shared types and constants of the session connection block.
package scs_pkg;

   localparam int SESSION_BITS = 64;
   localparam int SESSION_W    = 64;
   localparam int SEQ_W        = 32;
   localparam int TTL_W        = 27;

   typedef enum logic [2:0] {
      OP_PACKET     = 3'd0,
      OP_DATA       = 3'd1,
      OP_CONNECT    = 3'd2,
      OP_DISCONNECT = 3'd3,
      OP_REVIVE     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_CLOSED          = 3'd0,
      ST_CONNECT_SENT    = 3'd1,
      ST_ESTABLISHED     = 3'd2,
      ST_DISCONNECT_SENT = 3'd3,
      ST_REVIVE_SENT     = 3'd4,
      ST_DISCONNECTED    = 3'd5
   } conn_state_type;

   typedef struct packed {
      logic [2:0]           operation;
      logic                 rx_accept;
      logic                 rx_ack_flag;
      logic                 rx_connect_flag;
      logic                 rx_revive_flag;
      logic [SEQ_W-1:0]     rx_seq;
      logic [SEQ_W-1:0]     rx_ack;
      logic [TTL_W-1:0]     rx_ttl;
      logic [SESSION_W-1:0] rx_session;
   } req_type;

   typedef struct packed {
      logic                 send_valid;
      logic                 tx_ack_flag;
      logic                 tx_connect_flag;
      logic                 tx_revive_flag;
      logic [SEQ_W-1:0]     tx_seq;
      logic [SEQ_W-1:0]     tx_ack;
      logic [SESSION_W-1:0] tx_session;
      logic [2:0]           link_state;
      logic                 established;
      logic [TTL_W-1:0]     lifetime;
      logic                 revive_rejected;
   } rsp_type;

endpackage

@@ hdl/scs_ifs.sv @@
// Valid/ready channel interfaces for request and response items.
interface scs_req_if;
   import scs_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface scs_rsp_if;
   import scs_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/scs_core.sv @@
// Connection state registers and the per-item step logic.
module scs_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  scs_pkg::req_type item,
   output scs_pkg::rsp_type result
);
   import scs_pkg::*;

   conn_state_type          state_ff, state_in;
   logic [SEQ_W-1:0]        next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0]        last_ack_ff, last_ack_in;
   logic [SESSION_BITS-1:0] session_ff, session_in;
   logic [TTL_W-1:0]        ttl_ff, ttl_in;

   logic ack_only;
   logic seq_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLOSED;
         next_seq_ff <= '0;
         last_ack_ff <= '0;
         session_ff  <= '0;
         ttl_ff      <= '0;
      end else if (fire) begin
         state_ff    <= state_in;
         next_seq_ff <= next_seq_in;
         last_ack_ff <= last_ack_in;
         session_ff  <= session_in;
         ttl_ff      <= ttl_in;
      end
   end

   assign ack_only  = item.rx_ack_flag && !item.rx_connect_flag && !item.rx_revive_flag;
   assign seq_match = item.rx_ack == next_seq_ff;

   always_comb begin
      state_in    = state_ff;
      next_seq_in = next_seq_ff;
      last_ack_in = last_ack_ff;
      session_in  = session_ff;
      ttl_in      = ttl_ff;
      result      = '0;
      unique case (item.operation) inside
         OP_PACKET: begin
            unique case (state_ff) inside
               ST_CONNECT_SENT: begin
                  if (item.rx_accept) begin
                     ttl_in      = item.rx_ttl;
                     session_in  = item.rx_session[SESSION_BITS-1:0];
                     next_seq_in = item.rx_seq + SEQ_W'(1);
                     last_ack_in = item.rx_seq;
                     state_in    = ST_ESTABLISHED;
                  end
               end
               ST_ESTABLISHED, ST_DISCONNECT_SENT: begin
                  if (ack_only && seq_match) begin
                     next_seq_in = next_seq_ff + SEQ_W'(1);
                     last_ack_in = item.rx_seq;
                     ttl_in      = item.rx_ttl;
                     state_in    = (state_ff == ST_ESTABLISHED) ? ST_ESTABLISHED
                                                                : ST_DISCONNECTED;
                  end
               end
               ST_REVIVE_SENT: begin
                  if (!item.rx_accept) begin
                     // peer refused the revive: drop the link
                     state_in               = ST_DISCONNECTED;
                     result.revive_rejected = 1'b1;
                  end else if (ack_only && seq_match) begin
                     next_seq_in = next_seq_ff + SEQ_W'(1);
                     last_ack_in = item.rx_seq;
                     ttl_in      = item.rx_ttl;
                     state_in    = ST_ESTABLISHED;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_DATA, OP_DISCONNECT: begin
            if (state_ff == ST_ESTABLISHED) begin
               result.send_valid  = 1'b1;
               result.tx_ack_flag = 1'b1;
               result.tx_seq      = next_seq_ff;
               result.tx_ack      = last_ack_ff;
               result.tx_session  = SESSION_W'(session_ff);
               if (item.operation == OP_DISCONNECT) begin
                  result.tx_connect_flag = 1'b1;
                  result.tx_revive_flag  = 1'b1;
                  state_in               = ST_DISCONNECT_SENT;
               end
            end
         end
         OP_CONNECT: begin
            if (state_ff == ST_CLOSED) begin
               result.send_valid      = 1'b1;
               result.tx_connect_flag = 1'b1;
               state_in               = ST_CONNECT_SENT;
            end
         end
         OP_REVIVE: begin
            if (state_ff == ST_DISCONNECTED) begin
               result.send_valid     = 1'b1;
               result.tx_ack_flag    = 1'b1;
               result.tx_revive_flag = 1'b1;
               result.tx_seq         = next_seq_ff;
               result.tx_ack         = last_ack_ff;
               result.tx_session     = SESSION_W'(session_ff);
               state_in              = ST_REVIVE_SENT;
            end
         end
         default: begin
         end
      endcase
      result.link_state  = state_in;
      result.established = state_in == ST_ESTABLISHED;
      result.lifetime    = ttl_in;
   end

endmodule

@@ hdl/session_connection_fsm.sv @@
// Top level of the session connection block: input and result registers around the step.
//
//  channel   | dir | handshake          | payload
//  req_chan  | in  | valid/ready        | operation, rx_ flags, rx_seq, rx_ack, rx_ttl, rx_session
//  rsp_chan  | out | valid/ready        | send_valid, tx_ fields, link_state, lifetime, ...
//
// One item per cycle sustained while rsp_chan is ready.
// The step runs between the input register and the result register and
// updates the connection state as the item moves into the result register.
// Synchronous reset returns to closed with all numbers zero.
// A stalled result holds the input register; a new item is still taken as
// long as the input register empties in the same cycle.
module session_connection_fsm (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req_chan,
   scs_rsp_if.source rsp_chan
);
   import scs_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type step_result;
   logic    advance;
   logic    req_fire;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_chan.payload;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   scs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_ff),
      .result (step_result)
   );

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not filled after advance");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!in_valid_ff || advance))
      else $error("item taken while input register still held");

   a_reject_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.revive_rejected) |->
         (out_ff.link_state == ST_DISCONNECTED && !out_ff.send_valid))
      else $error("revive rejection without disconnect");

   a_idle_header: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.send_valid) |->
         (out_ff.tx_seq == '0 && out_ff.tx_session == '0 && !out_ff.tx_connect_flag))
      else $error("header fields set on refused request");

endmodule
